// ----- src/kcl_pkg.sv -----
// Shared constants, codes and the tone table for the keypad code lock.
// No dependencies; imported by keypad_code_lock_controller.
package kcl_pkg;

	localparam int CODE_DIGITS = 4;
	localparam int DIGIT_W     = 4;
	localparam int CODE_W      = CODE_DIGITS * DIGIT_W;
	localparam int COUNT_W     = 3;
	localparam int TONE_W      = 11;
	localparam int TICKS_W     = 16;
	localparam int TRIES_W     = 3;

	// event kinds on the input side
	localparam logic [1:0] FUNC_DIGIT  = 2'd0;
	localparam logic [1:0] FUNC_MENU   = 2'd1;
	localparam logic [1:0] FUNC_SCROLL = 2'd2;
	localparam logic [1:0] FUNC_TICK   = 2'd3;

	// menu buttons
	localparam logic [2:0] MENU_VERIFY = 3'd1;
	localparam logic [2:0] MENU_SET    = 3'd2;
	localparam logic [2:0] MENU_CHANGE = 3'd3;
	localparam logic [2:0] MENU_SOUND  = 3'd4;

	// controller modes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_VERIFY = 3'd1;
	localparam logic [2:0] MODE_SET    = 3'd2;
	localparam logic [2:0] MODE_OLD    = 3'd3;
	localparam logic [2:0] MODE_NEW    = 3'd4;

	// result status codes
	localparam logic [3:0] ST_IGNORED  = 4'd0;
	localparam logic [3:0] ST_DIGIT    = 4'd1;
	localparam logic [3:0] ST_OPENED   = 4'd2;
	localparam logic [3:0] ST_WRONG    = 4'd3;
	localparam logic [3:0] ST_LOCKED   = 4'd4;
	localparam logic [3:0] ST_STORED   = 4'd5;
	localparam logic [3:0] ST_SET_1ST  = 4'd6;
	localparam logic [3:0] ST_ALREADY  = 4'd7;
	localparam logic [3:0] ST_SOUND    = 4'd8;
	localparam logic [3:0] ST_SCROLLED = 4'd9;
	localparam logic [3:0] ST_RELEASED = 4'd10;
	localparam logic [3:0] ST_OLD_OK   = 4'd11;
	localparam logic [3:0] ST_STARTED  = 4'd12;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_ATTEMPTS  = 2'd0;
	localparam logic [1:0] REG_LOCKOUT_TICKS = 2'd1;

	localparam logic [TONE_W-1:0] TONE_SCROLL = 11'd494;
	localparam logic [TONE_W-1:0] TONE_OPEN   = 11'd1046;
	localparam logic [TONE_W-1:0] TONE_WRONG  = 11'd1000;
	localparam logic [TONE_W-1:0] TONE_LOCK   = 11'd500;

	typedef struct packed {
		logic [TONE_W-1:0]  tone_hz;
		logic               door_open;
		logic [COUNT_W-1:0] digits_entered;
		logic [1:0]         menu_page;
		logic               sound_flag;
		logic               locked_flag;
	} result_t;

	// key tone per digit; menu buttons reuse the tones of digits one to four
	function automatic logic [TONE_W-1:0] digit_tone(input logic [DIGIT_W-1:0] d);
		logic [TONE_W-1:0] hz;
		case (d)
			4'd0:    hz = 11'd523;
			4'd1:    hz = 11'd587;
			4'd2:    hz = 11'd659;
			4'd3:    hz = 11'd698;
			4'd4:    hz = 11'd784;
			4'd5:    hz = 11'd880;
			4'd6:    hz = 11'd987;
			4'd7:    hz = 11'd1046;
			4'd8:    hz = 11'd1175;
			4'd9:    hz = 11'd1319;
			default: hz = '0;
		endcase
		return hz;
	endfunction

endpackage

// ----- src/keypad_code_lock_controller.sv -----
// Keypad code lock controller: input register, one pass of decision logic,
// result register. Depends on kcl_pkg for codes, widths and the tone table.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser = func, tdata = key_digit, menu_choice
//  m_*      out  m_tvalid/m_tready   tuser = status, tdata = tone .. locked flag
//  cfg_*    in   cfg_valid/cfg_ready cfg_index selects register, cfg_data value
//
// A request sits in the input register while it is decided, and its result
// loads into the result register when the decision stage advances, from where
// it can be taken. A new request is accepted every cycle while results are
// being taken.
// A stalled result holds the result register, which in turn holds the input
// register; s_tready drops only when both are full.
// arst_n resets all control state, with sound on, and restores the register defaults.
module keypad_code_lock_controller
	import kcl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,   // [1:0] func
	input  logic [7:0]   s_tdata,   // [3:0] key_digit, [6:4] menu_choice, [7] zero
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [3:0]   m_tuser,   // [3:0] status
	output logic [23:0]  m_tdata,   // [10:0] tone_hz, [11] door_open,
	                                // [14:12] digits_entered, [16:15] menu_page,
	                                // [17] sound_flag, [18] locked_flag, [23:19] zero
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	// input register
	logic               in_vld_s1;
	logic [1:0]         func_s1;
	logic [DIGIT_W-1:0] digit_s1;
	logic [2:0]         choice_s1;

	// result register
	logic               out_vld_q;
	logic [3:0]         status_q;
	result_t            res_q;

	// configuration
	logic [TRIES_W-1:0] max_attempts_q;
	logic [TICKS_W-1:0] lockout_ticks_q;

	// controller state
	logic [2:0]         mode_q;
	logic [CODE_W-1:0]  stored_code_q;
	logic               code_valid_q;
	logic [CODE_W-1:0]  entry_code_q;
	logic [COUNT_W-1:0] digit_count_q;
	logic [TRIES_W-1:0] failed_tries_q;
	logic [TICKS_W-1:0] lockout_left_q;
	logic               sound_q;
	logic [1:0]         page_q;

	// next-state values
	logic [2:0]         mode_d;
	logic [CODE_W-1:0]  stored_code_d;
	logic               code_valid_d;
	logic [CODE_W-1:0]  entry_code_d;
	logic [COUNT_W-1:0] digit_count_d;
	logic [TRIES_W-1:0] failed_tries_d;
	logic [TICKS_W-1:0] lockout_left_d;
	logic               sound_d;
	logic [1:0]         page_d;
	logic [3:0]         status_d;
	logic [TONE_W-1:0]  tone_d;
	logic               door_d;
	logic [CODE_W-1:0]  shifted_code;
	logic [COUNT_W-1:0] count_inc;
	logic [TRIES_W-1:0] tries_inc;

	logic advance;

	// the decision stage moves when the result register is free or being emptied
	assign advance   = in_vld_s1 && (!out_vld_q || m_tready);
	assign s_tready  = !in_vld_s1 || advance;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_vld_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {5'd0, res_q.locked_flag, res_q.sound_flag, res_q.menu_page,
	                   res_q.digits_entered, res_q.door_open, res_q.tone_hz};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	// capture the request payload on acceptance
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1   <= s_tuser;
			digit_s1  <= s_tdata[3:0];
			choice_s1 <= s_tdata[6:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q  <= 3'd3;
			lockout_ticks_q <= 16'd10;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MAX_ATTEMPTS) begin
				max_attempts_q <= cfg_data[TRIES_W-1:0];
			end else if (cfg_index == REG_LOCKOUT_TICKS) begin
				lockout_ticks_q <= cfg_data;
			end
		end
	end

	assign shifted_code = {entry_code_q[CODE_W-DIGIT_W-1:0], digit_s1};
	assign count_inc    = digit_count_q + COUNT_W'(1);
	assign tries_inc    = failed_tries_q + TRIES_W'(1);

	// one pass over the request: every path is a few compares and a mux
	always_comb begin
		mode_d         = mode_q;
		stored_code_d  = stored_code_q;
		code_valid_d   = code_valid_q;
		entry_code_d   = entry_code_q;
		digit_count_d  = digit_count_q;
		failed_tries_d = failed_tries_q;
		lockout_left_d = lockout_left_q;
		sound_d        = sound_q;
		page_d         = page_q;
		status_d       = ST_IGNORED;
		tone_d         = '0;
		door_d         = 1'b0;

		if (func_s1 == FUNC_TICK) begin
			// count down the lockout; report release on the last tick
			if (lockout_left_q != '0) begin
				lockout_left_d = lockout_left_q - TICKS_W'(1);
				if (lockout_left_q == TICKS_W'(1)) begin
					status_d = ST_RELEASED;
				end
			end
		end else if (lockout_left_q != '0) begin
			// drop every key while locked out
		end else if (func_s1 == FUNC_SCROLL) begin
			if (mode_q == MODE_IDLE) begin
				page_d   = (page_q == 2'd2) ? 2'd0 : page_q + 2'd1;
				status_d = ST_SCROLLED;
				tone_d   = sound_q ? TONE_SCROLL : '0;
			end
		end else if (func_s1 == FUNC_MENU) begin
			if (mode_q == MODE_IDLE && choice_s1 >= MENU_VERIFY
			    && choice_s1 <= MENU_SOUND) begin
				tone_d = sound_q ? digit_tone({1'b0, choice_s1}) : '0;
				if (choice_s1 == MENU_SOUND) begin
					sound_d  = !sound_q;
					status_d = ST_SOUND;
				end else if (choice_s1 == MENU_SET) begin
					if (code_valid_q) begin
						status_d = ST_ALREADY;
					end else begin
						entry_code_d  = '0;
						digit_count_d = '0;
						mode_d        = MODE_SET;
						status_d      = ST_STARTED;
					end
				end else if (!code_valid_q) begin
					status_d = ST_SET_1ST;
				end else begin
					entry_code_d  = '0;
					digit_count_d = '0;
					mode_d        = (choice_s1 == MENU_VERIFY) ? MODE_VERIFY : MODE_OLD;
					status_d      = ST_STARTED;
				end
			end
		end else begin
			// digit key: only taken while an entry is open
			if (mode_q != MODE_IDLE && mode_q <= MODE_NEW && digit_s1 <= 4'd9) begin
				entry_code_d  = shifted_code;
				digit_count_d = count_inc;
				tone_d        = sound_q ? digit_tone(digit_s1) : '0;
				status_d      = ST_DIGIT;
				if (count_inc >= COUNT_W'(CODE_DIGITS)) begin
					case (mode_q)
						MODE_VERIFY: begin
							if (shifted_code == stored_code_q) begin
								failed_tries_d = '0;
								mode_d         = MODE_IDLE;
								status_d       = ST_OPENED;
								door_d         = 1'b1;
								tone_d         = sound_q ? TONE_OPEN : '0;
							end else if (tries_inc >= max_attempts_q) begin
								failed_tries_d = '0;
								lockout_left_d = lockout_ticks_q;
								mode_d         = MODE_IDLE;
								status_d       = ST_LOCKED;
								tone_d         = sound_q ? TONE_LOCK : '0;
							end else begin
								failed_tries_d = tries_inc;
								status_d       = ST_WRONG;
								tone_d         = sound_q ? TONE_WRONG : '0;
							end
						end
						MODE_OLD: begin
							// misses here are not counted toward lockout
							if (shifted_code == stored_code_q) begin
								mode_d   = MODE_NEW;
								status_d = ST_OLD_OK;
							end else begin
								status_d = ST_WRONG;
								tone_d   = sound_q ? TONE_WRONG : '0;
							end
						end
						default: begin
							stored_code_d = shifted_code;
							code_valid_d  = 1'b1;
							mode_d        = MODE_IDLE;
							status_d      = ST_STORED;
						end
					endcase
					entry_code_d  = '0;
					digit_count_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			stored_code_q  <= '0;
			code_valid_q   <= 1'b0;
			entry_code_q   <= '0;
			digit_count_q  <= '0;
			failed_tries_q <= '0;
			lockout_left_q <= '0;
			sound_q        <= 1'b1;
			page_q         <= '0;
		end else if (advance) begin
			mode_q         <= mode_d;
			stored_code_q  <= stored_code_d;
			code_valid_q   <= code_valid_d;
			entry_code_q   <= entry_code_d;
			digit_count_q  <= digit_count_d;
			failed_tries_q <= failed_tries_d;
			lockout_left_q <= lockout_left_d;
			sound_q        <= sound_d;
			page_q         <= page_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// load the result alongside the state update
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q             <= status_d;
			res_q.tone_hz        <= tone_d;
			res_q.door_open      <= door_d;
			res_q.digits_entered <= digit_count_d;
			res_q.menu_page      <= page_d;
			res_q.sound_flag     <= sound_d;
			res_q.locked_flag    <= (lockout_left_d != '0);
		end
	end

endmodule
